FILE: rtl/bitden_pkg.sv
package bitden_pkg;

   localparam int DEF_NUM_BITS = 1024;

   localparam int CMD_WIDTH   = 2;
   localparam int INDEX_WIDTH = 10;
   localparam int RANGE_WIDTH = 11;
   localparam int PCT_WIDTH   = 7;
   // ones * 100 stays below 2**18 for any range the 11-bit bounds can express
   localparam int PROD_WIDTH  = 18;
   localparam int QUOT_STEPS  = PCT_WIDTH;

   localparam int PERCENT_SCALE = 100;

   typedef logic [CMD_WIDTH-1:0]   cmd_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef logic [RANGE_WIDTH-1:0] range_type;
   typedef logic [PCT_WIDTH-1:0]   pct_type;

   localparam cmd_type CMD_SET = 2'd0;
   localparam cmd_type CMD_GET = 2'd1;
   localparam cmd_type CMD_AVG = 2'd2;

endpackage

FILE: rtl/bit_array_with_range_density.sv
// Bit array of NUM_BITS bits held as bytes in a RAM with one write and one
// read port, with set, get and range density commands.
// Request channel: req_valid/req_stall with command, bit index, bit value and
// a half-open range [range_start, range_end). Response channel:
// rsp_valid/rsp_stall with the read bit, the truncated percentage of ones in
// the range and an error flag. Every request gives exactly one response.
// Only one request is in work at a time; req_stall is low only when the
// sequencer is idle, so a new request may be taken while the previous
// response still waits in the output register.
// A rejected request goes straight to the output stage. A set or get reads
// its RAM byte, then modifies it or picks the bit. An average reads the bytes
// the range touches, one RAM read per cycle, then multiplies the count of
// ones by 100 and runs a 7-step shared compare/subtract divide.
// After reset the RAM is swept to zero, one byte per cycle, over all
// ceil(NUM_BITS/8) bytes (128 at the default) while req_stall stays high.
// When rsp_stall is high the response holds; a finished result waits in the
// sequencer until the output register is free.
module bit_array_with_range_density #(
   parameter int NUM_BITS = bitden_pkg::DEF_NUM_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bitden_pkg::cmd_type   req_command,
   input  bitden_pkg::index_type req_bit_index,
   input  logic                  req_bit_value,
   input  bitden_pkg::range_type req_range_start,
   input  bitden_pkg::range_type req_range_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_read_bit,
   output bitden_pkg::pct_type   rsp_percent_set,
   output logic                  rsp_error_flag
);

   import bitden_pkg::*;

   localparam int STORE_BYTES = (NUM_BITS + 7) / 8;
   localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int STEP_W      = $clog2(QUOT_STEPS);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_READ   = 4'd2;
   localparam logic [3:0] ST_MODIFY = 4'd3;
   localparam logic [3:0] ST_SCAN   = 4'd4;
   localparam logic [3:0] ST_DRAIN  = 4'd5;
   localparam logic [3:0] ST_MUL    = 4'd6;
   localparam logic [3:0] ST_DIV    = 4'd7;
   localparam logic [3:0] ST_OUT    = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic [AW-1:0]         clr_ff, clr_in;
   cmd_type               cmd_ff, cmd_in;
   index_type             idx_ff, idx_in;
   logic                  val_ff, val_in;
   range_type             lo_ff, lo_in;
   range_type             hi_ff, hi_in;
   logic [AW-1:0]         scan_ff, scan_in;
   logic                  dvld_ff, dvld_in;
   logic [AW-1:0]         dbyte_ff, dbyte_in;
   range_type             ones_ff, ones_in;
   logic [PROD_WIDTH-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  res_rd_ff, res_rd_in;
   logic                  res_err_ff, res_err_in;
   pct_type               res_pct_ff, res_pct_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_rd_ff, rsp_rd_in;
   pct_type               rsp_pct_ff, rsp_pct_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic                  accept;
   logic                  out_free;
   logic                  bad_req;
   logic [AW-1:0]         idx_byte;
   logic [AW-1:0]         lo_byte;
   logic [AW-1:0]         last_byte;
   range_type             hi_m1;
   range_type             span;
   logic [7:0]            lo_mask;
   logic [7:0]            hi_mask;
   logic [7:0]            scan_bits;
   logic [3:0]            scan_ones;
   logic [PROD_WIDTH-1:0] trial;

   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [7:0]            ram_wr_data;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   logic [7:0]            ram_rd_data;
   logic [7:0]            mod_byte;

   function automatic logic [3:0] popcount8(input logic [7:0] b);
      logic [3:0] n;
      n = 4'd0;
      for (int k = 0; k < 8; k++) begin
         n = n + 4'(b[k]);
      end
      return n;
   endfunction

   bitden_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (req_command)
         CMD_SET, CMD_GET: bad_req = (32'(req_bit_index) >= NUM_BITS);
         CMD_AVG: bad_req = (req_range_start >= req_range_end) ||
                            (32'(req_range_end) > NUM_BITS);
         default: bad_req = 1'b1;
      endcase
   end

   assign idx_byte  = AW'(32'(idx_ff) >> 3);
   assign lo_byte   = AW'(32'(lo_ff) >> 3);
   assign hi_m1     = hi_ff - range_type'(1);
   assign last_byte = AW'(32'(hi_m1) >> 3);
   assign span      = hi_ff - lo_ff;

   // drop bits of the edge bytes that fall outside the range
   assign lo_mask   = (dbyte_ff == lo_byte) ? (8'hFF << lo_ff[2:0]) : 8'hFF;
   assign hi_mask   = (dbyte_ff == last_byte) ? (8'hFF >> (3'd7 - hi_m1[2:0])) : 8'hFF;
   assign scan_bits = ram_rd_data & lo_mask & hi_mask;
   assign scan_ones = popcount8(scan_bits);

   assign trial = PROD_WIDTH'(span) << step_ff;

   always_comb begin
      mod_byte = ram_rd_data;
      mod_byte[idx_ff[2:0]] = val_ff;
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_byte;
      ram_wr_data = mod_byte;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_byte;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = 8'h00;
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
         end
         ST_MODIFY: begin
            ram_wr_en = (cmd_ff == CMD_SET);
         end
         ST_SCAN: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = scan_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      scan_in      = scan_ff;
      dvld_in      = (state_ff == ST_SCAN);
      dbyte_in     = scan_ff;
      ones_in      = ones_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      res_rd_in    = res_rd_ff;
      res_err_in   = res_err_ff;
      res_pct_in   = res_pct_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_err_in   = rsp_err_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // accumulate the byte read in the previous cycle
      if (dvld_ff) begin
         ones_in = ones_ff + range_type'(scan_ones);
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (32'(clr_ff) == STORE_BYTES - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in     = req_command;
               idx_in     = req_bit_index;
               val_in     = req_bit_value;
               lo_in      = req_range_start;
               hi_in      = req_range_end;
               scan_in    = AW'(32'(req_range_start) >> 3);
               ones_in    = '0;
               res_rd_in  = 1'b0;
               res_err_in = bad_req;
               res_pct_in = '0;
               if (bad_req) begin
                  state_in = ST_OUT;
               end else if (req_command == CMD_AVG) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (cmd_ff == CMD_GET) begin
               res_rd_in = ram_rd_data[idx_ff[2:0]];
            end
            state_in = ST_OUT;
         end
         ST_SCAN: begin
            scan_in = scan_ff + AW'(1);
            if (scan_ff == last_byte) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            rem_in   = PROD_WIDTH'(ones_ff) * PROD_WIDTH'(PERCENT_SCALE);
            step_in  = STEP_W'(QUOT_STEPS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // one quotient bit per cycle, most significant first
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               res_pct_in[step_ff] = 1'b1;
            end
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rd_in    = res_rd_ff;
               rsp_pct_in   = res_pct_ff;
               rsp_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         dvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         dvld_ff      <= dvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      idx_ff     <= idx_in;
      val_ff     <= val_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      scan_ff    <= scan_in;
      dbyte_ff   <= dbyte_in;
      ones_ff    <= ones_in;
      rem_ff     <= rem_in;
      step_ff    <= step_in;
      res_rd_ff  <= res_rd_in;
      res_err_ff <= res_err_in;
      res_pct_ff <= res_pct_in;
      rsp_rd_ff  <= rsp_rd_in;
      rsp_pct_ff <= rsp_pct_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_bit    = rsp_rd_ff;
   assign rsp_percent_set = rsp_pct_ff;
   assign rsp_error_flag  = rsp_err_ff;

endmodule

FILE: rtl/bitden_ram.sv
module bitden_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 128,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
